### src/tle_pkg.sv
// Shared constants and types for the terminal line editor.
`timescale 1ns / 1ps

package tle_pkg;

	// editing bytes
	localparam logic [7:0] K_DEL     = 8'h7F;
	localparam logic [7:0] K_BS      = 8'h08;
	localparam logic [7:0] K_KILL    = 8'h15;
	localparam logic [7:0] K_REPRINT = 8'h12;

	// echo bytes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_NL    = 8'h0A;

	localparam logic [7:0] END_CHAR_RESET = 8'h0A;

	typedef struct packed {
		logic       wr_en;
		logic       rd_en;
		logic [7:0] wr_data;
	} mem_cmd_t;

endpackage

### src/tle_line_mem.sv
// Line store: single-port-write, registered-read byte memory.
`timescale 1ns / 1ps

module tle_line_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  tle_pkg::mem_cmd_t cmd,
	input  logic [AW-1:0]     waddr,
	input  logic [AW-1:0]     raddr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[waddr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/tle_ctrl.sv
// Sequencer: decodes terminal bytes, updates the store and emits echo and line bytes.
`timescale 1ns / 1ps

module tle_ctrl #(
	parameter int LINE_SIZE = 16,
	parameter int AW        = 4,
	parameter int CW        = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic [7:0]        end_char,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              to_terminal,
	output logic              last_of_run,
	output tle_pkg::mem_cmd_t mem_cmd,
	output logic [AW-1:0]     mem_waddr,
	output logic [AW-1:0]     mem_raddr,
	input  logic [7:0]        mem_rdata,
	output logic [CW-1:0]     fill_cnt
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ECHO = 3'd1;
	localparam logic [2:0] S_HDR  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_PUT  = 3'd4;

	localparam logic [CW-1:0] FULL      = CW'(LINE_SIZE);
	localparam logic [CW-1:0] NEAR_FULL = CW'(LINE_SIZE - 1);
	localparam logic [CW-1:0] ONE       = CW'(1);

	logic [2:0]    state_q, state_d;
	logic [1:0]    phase_q, phase_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] len_q, len_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          kill_q, kill_d;
	logic          deliver_q, deliver_d;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          to_terminal_q;
	logic          last_q;

	logic       out_free;
	logic       ld;
	logic [7:0] ld_byte;
	logic       ld_term;
	logic       ld_last;
	logic       grp_last;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		idx_d     = idx_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		kill_d    = kill_q;
		deliver_d = deliver_q;
		ld        = 1'b0;
		ld_byte   = tle_pkg::CH_BS;
		ld_term   = 1'b1;
		ld_last   = 1'b0;
		grp_last  = !kill_q || (cnt_q == ONE);
		mem_cmd   = '0;
		mem_cmd.wr_data = in_byte;
		mem_waddr = cnt_q[AW-1:0];
		mem_raddr = idx_q[AW-1:0];

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_byte == tle_pkg::K_DEL || in_byte == tle_pkg::K_BS) begin
						if (cnt_q != '0) begin
							kill_d  = 1'b0;
							phase_d = 2'd0;
							state_d = S_ECHO;
						end
					end else if (in_byte == tle_pkg::K_KILL) begin
						if (cnt_q != '0) begin
							kill_d  = 1'b1;
							phase_d = 2'd0;
							state_d = S_ECHO;
						end
					end else if (in_byte == tle_pkg::K_REPRINT) begin
						phase_d   = 2'd0;
						len_d     = cnt_q;
						deliver_d = 1'b0;
						state_d   = S_HDR;
					end else if (in_byte == end_char) begin
						if (cnt_q < FULL) begin
							mem_cmd.wr_en = 1'b1;
							len_d     = cnt_q + ONE;
							cnt_d     = '0;
							idx_d     = '0;
							deliver_d = 1'b1;
							state_d   = S_RD;
						end
					end else if (cnt_q < NEAR_FULL) begin
						mem_cmd.wr_en = 1'b1;
						cnt_d = cnt_q + ONE;
					end
				end
			end
			S_ECHO: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_byte = (phase_q == 2'd1) ? tle_pkg::CH_SP : tle_pkg::CH_BS;
					if (phase_q == 2'd2) begin
						// one erase group done: drop the newest byte
						ld_last = grp_last;
						cnt_d   = cnt_q - ONE;
						phase_d = 2'd0;
						if (grp_last) begin
							state_d = S_IDLE;
						end
					end else begin
						phase_d = phase_q + 2'd1;
					end
				end
			end
			S_HDR: begin
				if (out_free) begin
					ld = 1'b1;
					case (phase_q)
						2'd0:    ld_byte = tle_pkg::CH_CARET;
						2'd1:    ld_byte = tle_pkg::CH_R;
						default: ld_byte = tle_pkg::CH_NL;
					endcase
					if (phase_q == 2'd2) begin
						ld_last = (len_q == '0);
						idx_d   = '0;
						phase_d = 2'd0;
						state_d = (len_q == '0) ? S_IDLE : S_RD;
					end else begin
						phase_d = phase_q + 2'd1;
					end
				end
			end
			S_RD: begin
				mem_cmd.rd_en = 1'b1;
				state_d = S_PUT;
			end
			S_PUT: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_byte = mem_rdata;
					ld_term = !deliver_q;
					ld_last = ((idx_q + ONE) == len_q);
					idx_d   = idx_q + ONE;
					state_d = ld_last ? S_IDLE : S_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 2'd0;
			idx_q       <= '0;
			len_q       <= '0;
			cnt_q       <= '0;
			kill_q      <= 1'b0;
			deliver_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			idx_q     <= idx_d;
			len_q     <= len_d;
			cnt_q     <= cnt_d;
			kill_q    <= kill_d;
			deliver_q <= deliver_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold payload until a new result replaces it
	always_ff @(posedge clk) begin
		if (ld) begin
			out_byte_q    <= ld_byte;
			to_terminal_q <= ld_term;
			last_q        <= ld_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign to_terminal = to_terminal_q;
	assign last_of_run = last_q;
	assign fill_cnt    = cnt_q;

endmodule

### src/terminal_line_editor.sv
// Top level of the terminal line editor: config register, sequencer and line store.
`timescale 1ns / 1ps

// Usage:
// Input channel (in_valid, in_stall, in_byte) takes one terminal byte per
// transaction; output channel (out_valid, out_stall, out_byte, to_terminal,
// last_of_run) returns echo bytes (to_terminal = 1) and delivered line bytes
// (to_terminal = 0), with last_of_run on the final result of each input byte.
// The config channel (cfg_valid, cfg_ready, end_char) sets the line terminator;
// write it only while the block is idle.
// Results per input byte: an ordinary byte, or an edit on an empty line, gives none;
// erase echoes backspace, space, backspace; kill echoes that group per stored byte;
// reprint echoes ^R and newline, then the stored bytes; end of line delivers the
// stored bytes with the terminator. Stored bytes are read one at a time, S_RD then
// S_PUT, because the line store has one read port with a registered read. in_stall
// stays high until the last result of a byte is loaded into the output register,
// so one result can still wait there while the next byte is taken. A stalled
// receiver freezes the sequencer in any state that loads a result.
// Reset clears the fill count and out_valid and sets end_char to newline;
// the store contents and the output payload are not cleared.

module terminal_line_editor #(
	parameter int LINE_SIZE = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       to_terminal,
	output logic       last_of_run,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] end_char
);

	localparam int AW = (LINE_SIZE > 1) ? $clog2(LINE_SIZE) : 1;
	localparam int CW = $clog2(LINE_SIZE + 1);

	logic [7:0]        end_char_q;
	tle_pkg::mem_cmd_t mem_cmd;
	logic [AW-1:0]     mem_waddr;
	logic [AW-1:0]     mem_raddr;
	logic [7:0]        mem_rdata;
	logic [CW-1:0]     fill_cnt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_char_q <= tle_pkg::END_CHAR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			end_char_q <= end_char;
		end
	end

	tle_ctrl #(
		.LINE_SIZE(LINE_SIZE),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.end_char(end_char_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.to_terminal(to_terminal),
		.last_of_run(last_of_run),
		.mem_cmd(mem_cmd),
		.mem_waddr(mem_waddr),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.fill_cnt(fill_cnt)
	);

	tle_line_mem #(
		.DEPTH(LINE_SIZE),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.cmd(mem_cmd),
		.waddr(mem_waddr),
		.raddr(mem_raddr),
		.rd_data(mem_rdata)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_cnt <= CW'(LINE_SIZE))
	else $error("fill count above line size");

	// while idle, only the final result of the previous byte may be pending
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_stall && out_valid) |-> last_of_run)
	else $error("non-final result pending while accepting input");

	a_deliver_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_byte == end_char_q
		 && in_byte != tle_pkg::K_DEL && in_byte != tle_pkg::K_BS
		 && in_byte != tle_pkg::K_KILL && in_byte != tle_pkg::K_REPRINT
		 && fill_cnt < CW'(LINE_SIZE)) |=> (fill_cnt == '0))
	else $error("line store not emptied on end of line");

endmodule

### verif/testbench.sv
// Self-checking testbench for the terminal line editor: directed table, then random lines.
`timescale 1ns / 1ps

module testbench;

	localparam int LINE_SIZE = 16;
	localparam int NUM_DIR = 16;
	localparam int SETTLE = 80;
	localparam int PHASE_ITEMS = 45;

	typedef struct packed {
		logic [7:0] ch;
		logic       term;
		logic       last;
	} res_t;

	// one row of the directed table; fixed rows carry their own expected results
	typedef struct packed {
		logic [7:0]       key;
		logic             fixed;
		logic [1:0]       n;
		logic             term;
		logic [0:2][7:0]  b;
	} row_t;

	localparam row_t [0:NUM_DIR-1] DIR_ROWS = '{
		// key                fixed  n     term  expected bytes
		'{tle_pkg::K_DEL,     1'b1, 2'd0, 1'b1, '{8'h00, 8'h00, 8'h00}},  // erase on empty line
		'{tle_pkg::K_BS,      1'b1, 2'd0, 1'b1, '{8'h00, 8'h00, 8'h00}},
		'{tle_pkg::K_KILL,    1'b1, 2'd0, 1'b1, '{8'h00, 8'h00, 8'h00}},  // kill on empty line
		// reprint on empty line
		'{tle_pkg::K_REPRINT, 1'b1, 2'd3, 1'b1,
			'{tle_pkg::CH_CARET, tle_pkg::CH_R, tle_pkg::CH_NL}},
		// terminator alone
		'{tle_pkg::CH_NL,     1'b1, 2'd1, 1'b0, '{tle_pkg::CH_NL, 8'h00, 8'h00}},
		'{8'h00,              1'b1, 2'd0, 1'b1, '{8'h00, 8'h00, 8'h00}},
		'{8'hFF,              1'b1, 2'd0, 1'b1, '{8'h00, 8'h00, 8'h00}},
		'{tle_pkg::K_DEL,     1'b1, 2'd3, 1'b1,
			'{tle_pkg::CH_BS, tle_pkg::CH_SP, tle_pkg::CH_BS}},
		'{8'h41,              1'b1, 2'd0, 1'b1, '{8'h00, 8'h00, 8'h00}},
		'{tle_pkg::K_REPRINT, 1'b0, 2'd0, 1'b1, '{8'h00, 8'h00, 8'h00}},
		'{tle_pkg::K_BS,      1'b1, 2'd3, 1'b1,
			'{tle_pkg::CH_BS, tle_pkg::CH_SP, tle_pkg::CH_BS}},
		'{tle_pkg::K_KILL,    1'b0, 2'd0, 1'b1, '{8'h00, 8'h00, 8'h00}},
		'{8'h80,              1'b1, 2'd0, 1'b1, '{8'h00, 8'h00, 8'h00}},
		'{tle_pkg::CH_NL,     1'b0, 2'd0, 1'b0, '{8'h00, 8'h00, 8'h00}},
		'{tle_pkg::K_KILL,    1'b1, 2'd0, 1'b1, '{8'h00, 8'h00, 8'h00}},
		'{tle_pkg::K_REPRINT, 1'b1, 2'd3, 1'b1,
			'{tle_pkg::CH_CARET, tle_pkg::CH_R, tle_pkg::CH_NL}}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       to_terminal;
	logic       last_of_run;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] end_char = 8'h00;

	row_t cur_row = '0;

	// model of the line store
	logic [7:0] line_buf [LINE_SIZE];
	logic [4:0] line_fill = 5'd0;
	logic [7:0] line_end = tle_pkg::END_CHAR_RESET;

	res_t step_res [$];
	res_t pending_out [$];

	int errors = 0;
	int sent = 0;
	int send_idle = 0;
	int stall_pct = 0;
	logic [7:0] term_byte = tle_pkg::END_CHAR_RESET;

	terminal_line_editor #(
		.LINE_SIZE(LINE_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.to_terminal(to_terminal),
		.last_of_run(last_of_run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.end_char(end_char)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic void push_res(input logic [7:0] ch, input logic term);
		res_t r;
		r.ch = ch;
		r.term = term;
		r.last = 1'b0;
		step_res.push_back(r);
	endfunction

	function automatic void push_erase();
		push_res(tle_pkg::CH_BS, 1'b1);
		push_res(tle_pkg::CH_SP, 1'b1);
		push_res(tle_pkg::CH_BS, 1'b1);
	endfunction

	// apply one terminal byte to the line model, leave its results in step_res
	function automatic void edit_line(input logic [7:0] c);
		int i;
		step_res.delete();
		if (c == tle_pkg::K_DEL || c == tle_pkg::K_BS) begin
			if (line_fill > 0) begin
				push_erase();
				line_fill--;
			end
		end else if (c == tle_pkg::K_KILL) begin
			while (line_fill > 0) begin
				push_erase();
				line_fill--;
			end
		end else if (c == tle_pkg::K_REPRINT) begin
			push_res(tle_pkg::CH_CARET, 1'b1);
			push_res(tle_pkg::CH_R, 1'b1);
			push_res(tle_pkg::CH_NL, 1'b1);
			for (i = 0; i < line_fill; i++)
				push_res(line_buf[i[3:0]], 1'b1);
		end else if (c == line_end) begin
			if (line_fill < LINE_SIZE) begin
				line_buf[line_fill[3:0]] = c;
				line_fill++;
				for (i = 0; i < line_fill; i++)
					push_res(line_buf[i[3:0]], 1'b0);
				line_fill = 5'd0;
			end
		end else if (line_fill < LINE_SIZE - 1) begin
			line_buf[line_fill[3:0]] = c;
			line_fill++;
		end
		if (step_res.size() > 0)
			step_res[step_res.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk) begin : monitor
		res_t want;
		res_t r;
		int k;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_out.size() == 0) begin
					$error("unexpected result: out_byte %h to_terminal %b last_of_run %b",
						out_byte, to_terminal, last_of_run);
					errors++;
				end else begin
					want = pending_out.pop_front();
					if (out_byte !== want.ch) begin
						$error("out_byte: expected %h, got %h", want.ch, out_byte);
						errors++;
					end
					if (to_terminal !== want.term) begin
						$error("to_terminal: expected %b, got %b", want.term, to_terminal);
						errors++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %b, got %b", want.last, last_of_run);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				line_end = end_char;
			if (in_valid && !in_stall) begin
				edit_line(in_byte);
				if (cur_row.fixed) begin
					for (k = 0; k < cur_row.n; k++) begin
						r.ch = cur_row.b[k[1:0]];
						r.term = cur_row.term;
						r.last = (k == cur_row.n - 1);
						pending_out.push_back(r);
					end
				end else begin
					for (k = 0; k < step_res.size(); k++)
						pending_out.push_back(step_res[k]);
				end
			end
		end
	end

	task automatic send_row(input row_t r);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= r.key;
		cur_row <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	task automatic send_byte(input logic [7:0] c);
		row_t r;
		r = '0;
		r.key = c;
		send_row(r);
	endtask

	// hold the sender until every expected result is out and the block is quiet
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_out.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_end_char(input logic [7:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		end_char <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		term_byte = v;
	endtask

	task automatic run_phase(input int idle_mode, input int quota);
		int start;
		int len;
		int k;
		int r;
		case (idle_mode)
			0: begin
				send_idle = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle = 78;
				stall_pct = 0;
			end
			2: begin
				send_idle = 0;
				stall_pct = 78;
			end
			default: begin
				send_idle = 9;
				stall_pct = 9;
			end
		endcase
		start = sent;
		while (sent - start < quota) begin
			r = $urandom_range(99);
			if (r < 15) begin
				// noise
				repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
			end else begin
				if (r < 35) begin
					// long line of 13 to 18 random bytes, can run into the full store
					len = $urandom_range(18, 13);
					for (k = 0; k < len; k++)
						send_byte(8'($urandom_range(255)));
				end else begin
					len = $urandom_range(10);
					for (k = 0; k < len; k++) begin
						r = $urandom_range(99);
						if (r < 5)
							send_byte(tle_pkg::K_DEL);
						else if (r < 9)
							send_byte(tle_pkg::K_BS);
						else if (r < 12)
							send_byte(tle_pkg::K_KILL);
						else if (r < 17)
							send_byte(tle_pkg::K_REPRINT);
						else
							send_byte(8'($urandom_range(255)));
					end
				end
				r = $urandom_range(9);
				if (r < 7)
					send_byte(term_byte);
				else if (r == 7)
					send_byte(tle_pkg::K_KILL);
				else if (r == 8)
					send_byte(tle_pkg::K_REPRINT);
			end
		end
	endtask

	initial begin
		logic [7:0] ends [6];
		int i;
		ends[0] = 8'h00;
		ends[1] = 8'hFF;
		ends[2] = tle_pkg::K_KILL;
		ends[3] = tle_pkg::K_BS;
		ends[4] = 8'($urandom_range(255));
		ends[5] = tle_pkg::END_CHAR_RESET;
		wait (arst_n == 1'b1);
		@(posedge clk);
		for (i = 0; i < NUM_DIR; i++)
			send_row(DIR_ROWS[i]);
		for (i = 0; i < 6; i++) begin
			write_end_char(ends[i]);
			run_phase(i % 4, PHASE_ITEMS);
		end
		wait_drained();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### terminal_line_editor.f
src/tle_pkg.sv
src/tle_line_mem.sv
src/tle_ctrl.sv
src/terminal_line_editor.sv
verif/testbench.sv
